@@ src/char_lcd_bus_sequencer_top_macros.svh @@
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_top_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_BUS_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_BUS_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CLBS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("char lcd bus sequencer check failed");

// next-cycle implication
`define CLBS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("char lcd bus sequencer check failed");

`endif

@@ src/clbs_pkg.sv @@
// ----------------------------------------------------------------------------
// clbs_pkg
// Types, constants and helpers for the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;

	localparam logic [7:0] ROW1_OFFSET = 8'h40;
	localparam logic [7:0] ROW2_OFFSET = 8'h10;
	localparam logic [7:0] ROW3_OFFSET = 8'h50;

	localparam logic [5:0] LEN_MIN   = 6'd8;
	localparam logic [5:0] LEN_MAX   = 6'd40;
	localparam logic [5:0] LEN_RESET = 6'd16;
	localparam logic [2:0] CNT_MIN   = 3'd1;
	localparam logic [2:0] CNT_MAX   = 3'd4;
	localparam logic [2:0] CNT_RESET = 3'd2;

	localparam logic REG_LINE_LENGTH = 1'b0;
	localparam logic REG_LINE_COUNT  = 1'b1;

	typedef enum logic [1:0] {
		REQ_INIT   = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_SETPOS = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_INIT = 2'd1,
		ST_BAD_POS  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [1:0] row;
		logic [5:0] col;
	} req_t;

	typedef struct packed {
		logic       reg_select;
		logic [7:0] bus_byte;
		logic       enable_level;
		logic [1:0] status;
		logic       last_beat;
	} beat_t;

	typedef struct packed {
		logic [5:0] line_length;
		logic [2:0] line_count;
	} cfg_t;

	typedef struct packed {
		logic       rs;
		logic [7:0] data;
	} slot_t;

	typedef struct packed {
		slot_t [3:0] slots;
		logic [1:0]  last_idx;
		logic        reject;
		status_t     status;
	} job_t;

	function automatic logic [7:0] row_offset(input logic [1:0] r);
		logic [7:0] o;
		unique case (r)
			2'd0: o = 8'h00;
			2'd1: o = ROW1_OFFSET;
			2'd2: o = ROW2_OFFSET;
			default: o = ROW3_OFFSET;
		endcase
		return o;
	endfunction

	function automatic logic [5:0] eff_len(input logic [5:0] v);
		logic [5:0] e;
		priority if (v < LEN_MIN) e = LEN_MIN;
		else if (v > LEN_MAX) e = LEN_MAX;
		else e = v;
		return e;
	endfunction

	function automatic logic [2:0] eff_cnt(input logic [2:0] v);
		logic [2:0] e;
		priority if (v < CNT_MIN) e = CNT_MIN;
		else if (v > CNT_MAX) e = CNT_MAX;
		else e = v;
		return e;
	endfunction

endpackage

@@ src/clbs_front.sv @@
// ----------------------------------------------------------------------------
// clbs_front
// Accepts requests, tracks init and cursor state, and builds byte jobs.
// ----------------------------------------------------------------------------
module clbs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  clbs_pkg::cfg_t  cfg,
	input  logic            req_valid,
	output logic            req_ready,
	input  clbs_pkg::req_t  req,
	input  logic            q_full,
	output logic            push,
	output clbs_pkg::job_t  job
);
	import clbs_pkg::*;

	logic       ready_q;
	logic [1:0] row_q;
	logic [5:0] col_q;
	logic       ready_nxt;
	logic [1:0] row_nxt;
	logic [5:0] col_nxt;
	logic [5:0] len;
	logic [2:0] cnt;
	logic [2:0] row_inc;
	logic [1:0] wrap_row;

	assign req_ready = !q_full;
	assign push      = req_valid && req_ready;
	assign len       = eff_len(cfg.line_length);
	assign cnt       = eff_cnt(cfg.line_count);
	assign row_inc   = {1'b0, row_q} + 3'd1;
	assign wrap_row  = (row_inc >= cnt) ? 2'd0 : row_inc[1:0];

	always_comb begin
		job       = '0;
		job.status = ST_OK;
		ready_nxt = ready_q;
		row_nxt   = row_q;
		col_nxt   = col_q;
		unique case (req_kind_t'(req.req_type))
			REQ_INIT: begin
				job.slots[0] = '{rs: 1'b0, data: CMD_FUNCTION_SET};
				job.slots[1] = '{rs: 1'b0, data: CMD_DISPLAY_ON};
				job.slots[2] = '{rs: 1'b0, data: CMD_CLEAR};
				job.slots[3] = '{rs: 1'b0, data: CMD_ENTRY_MODE};
				job.last_idx = 2'd3;
				ready_nxt    = 1'b1;
				row_nxt      = 2'd0;
				col_nxt      = 6'd0;
			end
			REQ_WRITE: begin
				if (!ready_q) begin
					job.reject = 1'b1;
					job.status = ST_NOT_INIT;
				end else if (col_q >= len) begin
					job.slots[0] = '{rs: 1'b0, data: CMD_SET_DDRAM + row_offset(wrap_row)};
					job.slots[1] = '{rs: 1'b1, data: req.char_code};
					job.last_idx = 2'd1;
					row_nxt      = wrap_row;
					col_nxt      = 6'd1;
				end else begin
					job.slots[0] = '{rs: 1'b1, data: req.char_code};
					col_nxt      = col_q + 6'd1;
				end
			end
			REQ_CLEAR: begin
				if (!ready_q) begin
					job.reject = 1'b1;
					job.status = ST_NOT_INIT;
				end else begin
					job.slots[0] = '{rs: 1'b0, data: CMD_CLEAR};
					row_nxt      = 2'd0;
					col_nxt      = 6'd0;
				end
			end
			REQ_SETPOS: begin
				if (!ready_q) begin
					job.reject = 1'b1;
					job.status = ST_NOT_INIT;
				end else if ({1'b0, req.row} >= cnt || req.col >= len) begin
					job.reject = 1'b1;
					job.status = ST_BAD_POS;
				end else begin
					job.slots[0] = '{rs: 1'b0,
						data: CMD_SET_DDRAM + {2'b00, req.col} + row_offset(req.row)};
					row_nxt      = req.row;
					col_nxt      = req.col;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			row_q   <= 2'd0;
			col_q   <= 6'd0;
		end else if (push) begin
			ready_q <= ready_nxt;
			row_q   <= row_nxt;
			col_q   <= col_nxt;
		end
	end

endmodule

@@ src/clbs_queue.sv @@
// ----------------------------------------------------------------------------
// clbs_queue
// Short job queue between the request front end and the bus back end.
// ----------------------------------------------------------------------------
module clbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clbs_pkg::job_t job_in,
	input  logic           pop,
	output clbs_pkg::job_t job_out,
	output logic           empty,
	output logic           full
);
	import clbs_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign job_out = mem_q[rd_q];
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			priority if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
			else cnt_q <= cnt_q;
		end
	end

endmodule

@@ src/clbs_back.sv @@
// ----------------------------------------------------------------------------
// clbs_back
// Walks the head job byte by byte and emits enable-high / enable-low beats, or one status beat for a rejected job.
// ----------------------------------------------------------------------------
module clbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  clbs_pkg::job_t  job,
	input  logic            empty,
	output logic            pop,
	output logic            beat_valid,
	input  logic            beat_ready,
	output clbs_pkg::beat_t beat
);
	import clbs_pkg::*;

	logic [1:0] idx_q;
	logic       phase_q;
	logic       valid_q;
	beat_t      beat_q;
	beat_t      beat_nxt;
	slot_t      cur;
	logic       take;
	logic       fin;

	assign cur  = job.slots[idx_q];
	assign take = !empty && (!valid_q || beat_ready);
	assign fin  = job.reject || (phase_q && idx_q == job.last_idx);
	assign pop  = take && fin;

	always_comb begin
		if (job.reject) begin
			beat_nxt = '{reg_select: 1'b0, bus_byte: 8'h00, enable_level: 1'b0,
				status: job.status, last_beat: 1'b1};
		end else begin
			beat_nxt = '{reg_select: cur.rs, bus_byte: cur.data, enable_level: !phase_q,
				status: ST_OK, last_beat: fin};
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_q <= beat_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
			phase_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
			if (fin) begin
				idx_q   <= 2'd0;
				phase_q <= 1'b0;
			end else if (phase_q) begin
				idx_q   <= idx_q + 2'd1;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end else if (beat_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign beat_valid = valid_q;
	assign beat       = beat_q;

endmodule

@@ src/char_lcd_bus_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_top
// 8-bit character LCD bus sequencer with APB line geometry registers.
// ----------------------------------------------------------------------------
// Each request turns into bus beats, two per byte (enable high, then enable
// low): 8 beats for init, 2 for clear, set position or a plain character,
// 4 for a character that wraps to the next line, and one status beat for a
// rejected request. The beat output emits one beat per cycle while beat_ready
// is high and a job is queued; the front end takes a request per cycle as long
// as its two-entry job queue has room.
// Registers: line_length at 0x0, line_count at 0x4; write them only while idle.
module char_lcd_bus_sequencer_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            req_valid,
	output logic            req_ready,
	input  clbs_pkg::req_t  req,
	output logic            beat_valid,
	input  logic            beat_ready,
	output clbs_pkg::beat_t beat
);
	import clbs_pkg::*;

	cfg_t cfg_q;
	logic reg_idx;
	logic cfg_wr;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;
	job_t job_in;
	job_t job_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_length <= LEN_RESET;
			cfg_q.line_count  <= CNT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LINE_LENGTH: cfg_q.line_length <= pwdata[5:0];
				REG_LINE_COUNT:  cfg_q.line_count  <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LINE_LENGTH: prdata = {26'd0, cfg_q.line_length};
			REG_LINE_COUNT:  prdata = {29'd0, cfg_q.line_count};
		endcase
	end

	clbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.job       (job_in)
	);

	clbs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_head),
		.empty   (q_empty),
		.full    (q_full)
	);

	clbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job_head),
		.empty      (q_empty),
		.pop        (pop),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat)
	);

endmodule

@@ src/clbs_checker.sv @@
// ----------------------------------------------------------------------------
// clbs_checker
// Port-level checks on the beat stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_bus_sequencer_top_macros.svh"

module clbs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            beat_valid,
	input logic            beat_ready,
	input clbs_pkg::beat_t beat
);
	import clbs_pkg::*;

	`CLBS_ASSERT_NXT(a_beat_hold, beat_valid && !beat_ready, beat_valid && $stable(beat))
	`CLBS_ASSERT_IMP(a_reject_shape, beat_valid && beat.status != ST_OK, beat.last_beat && !beat.enable_level && !beat.reg_select && beat.bus_byte == 8'h00)
	`CLBS_ASSERT_IMP(a_high_not_last, beat_valid && beat.enable_level, !beat.last_beat)
	`CLBS_ASSERT_NXT(a_low_follows_high, beat_valid && beat_ready && beat.enable_level, beat_valid && !beat.enable_level && beat.bus_byte == $past(beat.bus_byte) && beat.reg_select == $past(beat.reg_select))

endmodule

bind char_lcd_bus_sequencer_top clbs_checker u_clbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.beat_valid (beat_valid),
	.beat_ready (beat_ready),
	.beat       (beat)
);
